@@ rtl/bfs_pkg.sv @@
// Shared widths, request codes, types and level helpers for the brightness fade stepper.
`default_nettype none

package bfs_pkg;

  localparam int REQ_W = 2;
  localparam int FRM_W = 8;
  localparam int LVL_W = 6;
  localparam int PLN_W = 6;
  localparam int DSP_W = 2;
  // Magnitude of start minus target after clamping: at most 32
  localparam int MAG_W = 6;
  // Remainder accumulator stays below twice the frame count
  localparam int ACC_W = FRM_W + 1;
  // Restoring divider retires one quotient bit per cycle
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  localparam logic signed [LVL_W-1:0] LVL_MIN = -6'sd16;
  localparam logic signed [LVL_W-1:0] LVL_MAX = 6'sd16;

  typedef logic signed [LVL_W-1:0] level_t;

  // Command from the sequencer to one channel
  typedef struct packed {
    logic             apply;
    logic [REQ_W-1:0] req;
    logic             sel;
    logic             frames_nz;
  } chan_cmd_t;

  // Fade set-up shared by all channels of one start request
  typedef struct packed {
    logic [FRM_W-1:0] frames;
    level_t           target;
    level_t           start;
    logic             down;
    logic [MAG_W-1:0] whole;
    logic [FRM_W-1:0] frac;
    logic [PLN_W-1:0] planes;
  } fade_setup_t;

  // What one channel writes for the pending request, and its busy flag after it
  typedef struct packed {
    logic             wr;
    level_t           level;
    logic [PLN_W-1:0] planes;
    logic             busy;
  } chan_out_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic last;
  } div_status_t;

  // Clamp a raw level to the blend range
  function automatic level_t sat_level(input logic [LVL_W-1:0] raw);
    level_t v;
    v = level_t'(raw);
    if (v < LVL_MIN) begin
      return LVL_MIN;
    end else if (v > LVL_MAX) begin
      return LVL_MAX;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bfs_if.sv @@
// Request and result channel interfaces of the brightness fade stepper.
`default_nettype none

interface bfs_req_if
  import bfs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [FRM_W-1:0] frame_count;
  logic signed [LVL_W-1:0] target_level;
  logic signed [LVL_W-1:0] start_level;
  logic [PLN_W-1:0] plane_mask;
  logic [DSP_W-1:0] display_mask;

  modport source (
    output valid, req_type, frame_count, target_level, start_level, plane_mask,
           display_mask,
    input  ready
  );
  modport sink (
    input  valid, req_type, frame_count, target_level, start_level, plane_mask,
           display_mask,
    output ready
  );
endinterface

interface bfs_res_if
  import bfs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             main_write;
  logic signed [LVL_W-1:0] main_level;
  logic [PLN_W-1:0] main_planes;
  logic             sub_write;
  logic signed [LVL_W-1:0] sub_level;
  logic [PLN_W-1:0] sub_planes;
  logic             fade_done;

  modport source (
    output valid, main_write, main_level, main_planes, sub_write, sub_level, sub_planes,
           fade_done,
    input  ready
  );
  modport sink (
    input  valid, main_write, main_level, main_planes, sub_write, sub_level, sub_planes,
           fade_done,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/bfs_div.sv @@
// Bit-serial restoring divider: level difference by frame count, one quotient bit a cycle.
`default_nettype none

module bfs_div
  import bfs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MAG_W-1:0] dividend_i,
  input  wire logic [FRM_W-1:0] divisor_i,
  output      div_status_t      status_o,
  output      logic [MAG_W-1:0] quot_o,
  output      logic [FRM_W-1:0] rem_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]     num_q, num_d;
  logic [FRM_W-1:0]     rem_q, rem_d;
  logic [FRM_W-1:0]     den_q, den_d;
  logic [ACC_W-1:0]     trial;
  logic                 fits;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, num_q[MAG_W-1]};
    fits  = trial >= {1'b0, den_q};
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_STEPS);
      num_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      num_d = {num_q[MAG_W-2:0], fits};
      rem_d = fits ? FRM_W'(trial - {1'b0, den_q}) : FRM_W'(trial);
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Operand shift registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign status_o.busy = cnt_q != '0;
  assign status_o.last = cnt_q == DIV_CNT_W'(1);
  assign quot_o        = num_q;
  assign rem_o         = rem_q;

endmodule

`default_nettype wire

@@ rtl/bfs_chan.sv @@
// One display channel: fade state and the per-tick Bresenham step.
`default_nettype none

module bfs_chan
  import bfs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire chan_cmd_t   cmd_i,
  input  wire fade_setup_t setup_i,
  output      chan_out_t   out_o
);

  logic             busy_q, busy_d;
  level_t           cur_q, cur_d;
  level_t           goal_q, goal_d;
  logic             down_q, down_d;
  logic [MAG_W-1:0] whole_q, whole_d;
  logic [FRM_W-1:0] frac_q, frac_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [FRM_W-1:0] frames_q, frames_d;
  logic [PLN_W-1:0] planes_q, planes_d;

  logic signed [LVL_W:0] step;
  logic signed [LVL_W:0] nxt;
  logic [ACC_W-1:0]      acc_sum;
  level_t                lvl_carry;

  // Tick arithmetic
  always_comb begin
    step      = down_q ? -$signed({1'b0, whole_q}) : $signed({1'b0, whole_q});
    nxt       = $signed({cur_q[LVL_W-1], cur_q}) + step;
    acc_sum   = acc_q + {1'b0, frac_q};
    lvl_carry = down_q ? level_t'(nxt[LVL_W-1:0] - 1'b1)
                       : level_t'(nxt[LVL_W-1:0] + 1'b1);
  end

  // Next state and write for the pending request
  always_comb begin
    busy_d   = busy_q;
    cur_d    = cur_q;
    goal_d   = goal_q;
    down_d   = down_q;
    whole_d  = whole_q;
    frac_d   = frac_q;
    acc_d    = acc_q;
    frames_d = frames_q;
    planes_d = planes_q;
    out_o    = '0;
    case (cmd_i.req)
      REQ_START: begin
        if (cmd_i.sel && cmd_i.frames_nz) begin
          busy_d   = 1'b1;
          cur_d    = setup_i.start;
          goal_d   = setup_i.target;
          down_d   = setup_i.down;
          whole_d  = setup_i.whole;
          frac_d   = setup_i.frac;
          acc_d    = '0;
          frames_d = setup_i.frames;
          planes_d = setup_i.planes;
          out_o.wr     = 1'b1;
          out_o.level  = setup_i.start;
          out_o.planes = setup_i.planes;
        end
      end
      REQ_SET: begin
        if (cmd_i.sel) begin
          busy_d   = 1'b0;
          cur_d    = '0;
          goal_d   = '0;
          down_d   = 1'b0;
          whole_d  = '0;
          frac_d   = '0;
          acc_d    = '0;
          frames_d = '0;
          planes_d = '0;
          out_o.wr     = 1'b1;
          out_o.level  = setup_i.target;
          out_o.planes = setup_i.planes;
        end
      end
      REQ_TICK: begin
        if (busy_q) begin
          if (nxt != $signed({goal_q[LVL_W-1], goal_q}) && cur_q != goal_q) begin
            cur_d = level_t'(nxt[LVL_W-1:0]);
            acc_d = acc_sum;
            if (acc_sum >= {1'b0, frames_q}) begin
              cur_d = lvl_carry;
              if (lvl_carry != goal_q) begin
                acc_d = acc_sum - {1'b0, frames_q};
              end else begin
                busy_d = 1'b0;
              end
            end
          end else begin
            cur_d  = goal_q;
            busy_d = 1'b0;
          end
          out_o.wr     = 1'b1;
          out_o.level  = cur_d;
          out_o.planes = planes_q;
        end
      end
      default: begin
      end
    endcase
    out_o.busy = busy_d;
  end

  // Channel state, updated when the result is issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cur_q    <= '0;
      goal_q   <= '0;
      down_q   <= 1'b0;
      whole_q  <= '0;
      frac_q   <= '0;
      acc_q    <= '0;
      frames_q <= '0;
      planes_q <= '0;
    end else if (cmd_i.apply) begin
      busy_q   <= busy_d;
      cur_q    <= cur_d;
      goal_q   <= goal_d;
      down_q   <= down_d;
      whole_q  <= whole_d;
      frac_q   <= frac_d;
      acc_q    <= acc_d;
      frames_q <= frames_d;
      planes_q <= planes_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/brightness_fade_stepper.sv @@
// Brightness fade stepper top level: request sequencer, serial divider, display channels.
//
// Usage: requests arrive on req_i (valid/ready); each request gives exactly one
// result on res_o (valid/ready). A start request with a nonzero frame count sets up a
// linear fade on the selected displays, a set request writes a level and clears the
// selected displays, and a tick request advances every busy display by one frame.
// Flow: a tick, set or ignored request is captured on acceptance and then
// committed to the output register; the next request is taken only once the
// sequencer is back in idle. A start with a nonzero frame count runs the six-step
// bit-serial divider (difference over frame count) before the commit.
// The result sits in an output register: while it waits the block takes and
// works on the next request, and only issues that one once the register has
// been taken. A stalled receiver therefore holds at most one further request.
// Reset clears every display to idle at level zero; no request is pending.
`default_nettype none

module brightness_fade_stepper
  import bfs_pkg::*;
#(
  parameter int NUM_DISPLAYS = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfs_req_if.sink   req_i,
  bfs_res_if.source res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  logic             req_fire;
  logic             start_go;
  level_t           tgt_sat, start_sat;
  logic signed [LVL_W:0] diff;
  logic             down_in;
  logic [MAG_W-1:0] mag_in;

  logic [REQ_W-1:0] req_q;
  logic [FRM_W-1:0] frames_q;
  level_t           tgt_q, start_q;
  logic             down_q;
  logic [PLN_W-1:0] planes_q;
  logic [DSP_W-1:0] dmask_q;

  div_status_t      div_st;
  logic [MAG_W-1:0] quot;
  logic [FRM_W-1:0] rem;

  fade_setup_t      setup;
  chan_out_t        chan_out [DSP_W];
  logic             commit;
  logic             res_free;
  logic             res_valid_q;
  logic             done;

  // Clamp incoming levels and find fade direction and magnitude
  always_comb begin
    tgt_sat   = sat_level(req_i.target_level);
    start_sat = sat_level(req_i.start_level);
    diff      = $signed({start_sat[LVL_W-1], start_sat})
              - $signed({tgt_sat[LVL_W-1], tgt_sat});
    down_in   = diff > 0;
    mag_in    = down_in ? MAG_W'(diff) : MAG_W'(-diff);
  end

  assign req_i.ready = state_q == ST_IDLE;
  assign req_fire    = req_i.valid && req_i.ready;
  assign start_go    = req_fire && (req_i.req_type == REQ_START) && (req_i.frame_count != '0);
  assign res_free    = !res_valid_q || res_o.ready;
  assign commit      = (state_q == ST_OUT) && res_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = start_go ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_st.last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q    <= req_i.req_type;
      frames_q <= req_i.frame_count;
      tgt_q    <= tgt_sat;
      start_q  <= start_sat;
      down_q   <= down_in;
      planes_q <= req_i.plane_mask;
      dmask_q  <= req_i.display_mask;
    end
  end

  bfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_go),
    .dividend_i (mag_in),
    .divisor_i  (req_i.frame_count),
    .status_o   (div_st),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    setup.frames = frames_q;
    setup.target = tgt_q;
    setup.start  = start_q;
    setup.down   = down_q;
    setup.whole  = quot;
    setup.frac   = rem;
    setup.planes = planes_q;
  end

  // Display channels; absent ones never write and count as idle
  for (genvar c = 0; c < DSP_W; c++) begin : g_chan
    if (c < NUM_DISPLAYS) begin : g_on
      chan_cmd_t cmd;
      assign cmd.apply     = commit;
      assign cmd.req       = req_q;
      assign cmd.sel       = dmask_q[c];
      assign cmd.frames_nz = frames_q != '0;
      bfs_chan u_chan (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cmd_i   (cmd),
        .setup_i (setup),
        .out_o   (chan_out[c])
      );
    end else begin : g_off
      assign chan_out[c] = '0;
    end
  end

  assign done = (dmask_q != '0)
             && !(dmask_q[0] && chan_out[0].busy)
             && !(dmask_q[1] && chan_out[1].busy);

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (commit) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_o.main_write  <= chan_out[0].wr;
      res_o.main_level  <= chan_out[0].level;
      res_o.main_planes <= chan_out[0].planes;
      res_o.sub_write   <= chan_out[1].wr;
      res_o.sub_level   <= chan_out[1].level;
      res_o.sub_planes  <= chan_out[1].planes;
      res_o.fade_done   <= done;
    end
  end

  assign res_o.valid = res_valid_q;

`ifndef SYNTHESIS
  // A request is only taken once the divider has finished
  a_div_idle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> !div_st.busy)
    else $error("request accepted while divider running");

  // Written main levels stay inside the blend range
  a_main_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.main_write) |->
      ($signed(res_o.main_level) >= LVL_MIN && $signed(res_o.main_level) <= LVL_MAX))
    else $error("main level out of range");

  // A channel that does not write reports zero level and planes
  a_sub_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.sub_write) |->
      (res_o.sub_level == '0 && res_o.sub_planes == '0))
    else $error("sub fields set without a write");
`endif

endmodule

`default_nettype wire
